// File: rtl/core/avtc_pkg.sv
package avtc_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int FRAC_W     = 4;
	localparam int VOLT_W     = 20;
	localparam int TEMP_W     = 16;
	localparam int DIV_NUM_W  = 48;
	localparam int DIV_DEN_W  = 24;
	localparam int DIV_Q_W    = 20;
	localparam int DIV_LAT    = DIV_Q_W + 1;

	localparam logic [15:0] SUPPLY_K     = 16'd52800;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;
	localparam logic [1:0] REG_REF_CAL   = 2'd0;
	localparam logic [1:0] REG_TEMP_LOW  = 2'd1;
	localparam logic [1:0] REG_TEMP_HIGH = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REF_ZERO  = 2'd1;
	localparam logic [1:0] ST_CAL_EQUAL = 2'd2;

	localparam logic [VOLT_W-1:0] VOLT_MAX = {VOLT_W{1'b1}};

	typedef struct packed {
		logic [1:0] status;
		logic       tneg;
	} meta_t;

endpackage

// File: rtl/core/avtc_div.sv
module avtc_div
	import avtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 en,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_Q_W-1:0]   quo,
	output logic                 ovf
);

	logic [DIV_NUM_W-1:0] rem_s [0:DIV_Q_W];
	logic [DIV_DEN_W-1:0] den_s [0:DIV_Q_W];
	logic [DIV_Q_W-1:0]   quo_s [0:DIV_Q_W];
	logic                 ovf_s [0:DIV_Q_W];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			ovf_s[0] <= num >= {{(DIV_NUM_W-DIV_DEN_W-DIV_Q_W){1'b0}}, den, {DIV_Q_W{1'b0}}};
		end
	end

	for (genvar i = 0; i < DIV_Q_W; i++) begin : g_step
		logic [DIV_NUM_W-1:0] trial;
		logic                 take;
		assign trial = {{(DIV_NUM_W-DIV_DEN_W){1'b0}}, den_s[i]} << (DIV_Q_W-1-i);
		assign take  = rem_s[i] >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? rem_s[i] - trial : rem_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= quo_s[i] | (take ? ({{(DIV_Q_W-1){1'b0}}, 1'b1} << (DIV_Q_W-1-i))
					: '0);
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	assign quo = quo_s[DIV_Q_W];
	assign ovf = ovf_s[DIV_Q_W];

endmodule

// File: rtl/core/adc_vrefint_temperature_calibration.sv
// ADC supply and die temperature calibration.
// Slave stream s_axis: one beat carries a set of five 12-bit raw codes.
// Master stream m_axis: one beat per input beat with the supply, four scaled
// voltages in mV x16, the die temperature in degrees C x16, and in tuser the
// status and saturation flag.
// Configuration: cfg_we with cfg_index 0 (reference cal code), 1 (30 degree
// code), 2 (110 degree code); other indexes are ignored. Write only while idle.
// Pipeline: 25 register stages (three arithmetic stages, a 21-stage restoring
// divider array, one output register); the first loads at the accepting edge
// of the input beat.
// Throughput: one beat per cycle unless stalled; the divider array takes one
// quotient bit per step stage, so every stage holds a different item.
// Reset: clears all valid bits and loads the default calibration codes.
// Stall: while m_axis_tready is low and a beat waits, the whole pipeline
// holds and s_axis_tready drops; nothing is lost or repeated.
module adc_vrefint_temperature_calibration
	import avtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// raw_pin0, raw_pin1, raw_sensor, raw_ref, raw_batt, zero fill
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// supply_mv_q4, pin0_mv_q4, pin1_mv_q4, ref_mv_q4, batt_mv_q4, temp_c_q4, zero fill
	output logic [119:0] m_axis_tdata,
	// status, saturated
	output logic [2:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [11:0]  cfg_wdata
);

	logic [SAMPLE_W-1:0] cal_q, tlo_q, thi_q;
	logic                adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= 12'd1500;
			tlo_q <= 12'd940;
			thi_q <= 12'd1210;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REF_CAL:   cal_q <= cfg_wdata;
				REG_TEMP_LOW:  tlo_q <= cfg_wdata;
				REG_TEMP_HIGH: thi_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [SAMPLE_W-1:0] r_pin0, r_pin1, r_temp, r_ref, r_batt;
	assign r_pin0 = s_axis_tdata[11:0];
	assign r_pin1 = s_axis_tdata[23:12];
	assign r_temp = s_axis_tdata[35:24];
	assign r_ref  = s_axis_tdata[47:36];
	assign r_batt = s_axis_tdata[59:48];

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1
	logic               v_s1;
	logic [23:0]        p0_s1, p1_s1, pr_s1, pb_s1, ta_s1, tb_s1, den_s1;
	logic [27:0]        sup_s1;
	logic [11:0]        rref_s1;
	logic signed [25:0] d_s1;
	meta_t              meta_s1;
	logic signed [12:0] cal_diff;

	assign cal_diff = $signed({1'b0, thi_q}) - $signed({1'b0, tlo_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1   <= r_pin0 * cal_q;
			p1_s1   <= r_pin1 * cal_q;
			pr_s1   <= r_ref * cal_q;
			pb_s1   <= r_batt * cal_q;
			ta_s1   <= r_temp * cal_q;
			tb_s1   <= tlo_q * r_ref;
			den_s1  <= {r_ref, 12'd0} - {12'd0, r_ref};
			rref_s1 <= r_ref;
			sup_s1  <= cal_q * SUPPLY_K;
			d_s1    <= $signed({1'b0, r_ref}) * cal_diff;
			meta_s1.tneg <= 1'b0;
			if (r_ref == '0) meta_s1.status <= ST_REF_ZERO;
			else if (thi_q == tlo_q) meta_s1.status <= ST_CAL_EQUAL;
			else meta_s1.status <= ST_OK;
		end
	end

	// stage 2
	logic               v_s2;
	logic [39:0]        v0_s2, v1_s2, vr_s2;
	logic [40:0]        vb_s2;
	logic [23:0]        den_s2;
	logic [11:0]        rref_s2;
	logic [27:0]        sup_s2;
	logic signed [25:0] d_s2, n_s2;
	meta_t              meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v0_s2   <= p0_s1 * SUPPLY_K;
			v1_s2   <= p1_s1 * SUPPLY_K;
			vr_s2   <= pr_s1 * SUPPLY_K;
			vb_s2   <= {40'(pb_s1 * SUPPLY_K), 1'b0};
			den_s2  <= den_s1;
			rref_s2 <= rref_s1;
			sup_s2  <= sup_s1;
			d_s2    <= d_s1;
			n_s2    <= $signed({2'b0, ta_s1}) - $signed({2'b0, tb_s1});
			meta_s2 <= meta_s1;
		end
	end

	// stage 3
	logic               v_s3;
	logic [DIV_NUM_W-1:0] n0_s3, n1_s3, nr_s3, nb_s3, ns_s3, nt_s3;
	logic [DIV_DEN_W-1:0] den_s3, rref_s3, dt_s3;
	meta_t              meta_s3;
	logic signed [37:0] tnum;
	logic [37:0]        tmag;
	logic [25:0]        dmag;

	assign tnum = (38'(d_s2) * 38'sd30 + 38'(n_s2) * 38'sd80) <<< FRAC_W;
	assign tmag = tnum[37] ? 38'(-tnum) : 38'(tnum);
	assign dmag = d_s2[25] ? 26'(-d_s2) : 26'(d_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n0_s3   <= 48'(v0_s2);
			n1_s3   <= 48'(v1_s2);
			nr_s3   <= 48'(vr_s2);
			nb_s3   <= 48'(vb_s2);
			ns_s3   <= 48'(sup_s2);
			nt_s3   <= 48'(tmag);
			den_s3  <= den_s2;
			rref_s3 <= 24'(rref_s2);
			dt_s3   <= dmag[23:0];
			meta_s3.status <= meta_s2.status;
			meta_s3.tneg   <= tnum[37] ^ d_s2[25];
		end
	end

	// divider array
	logic [DIV_Q_W-1:0] q_sup, q_p0, q_p1, q_ref, q_bat, q_tmp;
	logic               o_sup, o_p0, o_p1, o_ref, o_bat, o_tmp;

	avtc_div u_div_sup (.clk, .en(adv), .num(ns_s3), .den(rref_s3), .quo(q_sup), .ovf(o_sup));
	avtc_div u_div_p0  (.clk, .en(adv), .num(n0_s3), .den(den_s3),  .quo(q_p0),  .ovf(o_p0));
	avtc_div u_div_p1  (.clk, .en(adv), .num(n1_s3), .den(den_s3),  .quo(q_p1),  .ovf(o_p1));
	avtc_div u_div_ref (.clk, .en(adv), .num(nr_s3), .den(den_s3),  .quo(q_ref), .ovf(o_ref));
	avtc_div u_div_bat (.clk, .en(adv), .num(nb_s3), .den(den_s3),  .quo(q_bat), .ovf(o_bat));
	avtc_div u_div_tmp (.clk, .en(adv), .num(nt_s3), .den(dt_s3),   .quo(q_tmp), .ovf(o_tmp));

	logic  vd_q   [0:DIV_LAT-1];
	meta_t meta_q [0:DIV_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
		end else if (adv) begin
			vd_q[0] <= v_s3;
			for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_q[0] <= meta_s3;
			for (int i = 1; i < DIV_LAT; i++) meta_q[i] <= meta_q[i-1];
		end
	end

	// finalize
	logic [VOLT_W-1:0]  f_sup, f_p0, f_p1, f_ref, f_bat;
	logic [TEMP_W-1:0]  f_tmp;
	logic               s_volt, s_tmp;
	meta_t              mo;

	assign mo    = meta_q[DIV_LAT-1];
	assign f_sup = o_sup ? VOLT_MAX : q_sup;
	assign f_p0  = o_p0  ? VOLT_MAX : q_p0;
	assign f_p1  = o_p1  ? VOLT_MAX : q_p1;
	assign f_ref = o_ref ? VOLT_MAX : q_ref;
	assign f_bat = o_bat ? VOLT_MAX : q_bat;
	assign s_volt = o_sup | o_p0 | o_p1 | o_ref | o_bat;

	always_comb begin
		f_tmp = '0;
		s_tmp = 1'b0;
		if (mo.tneg) begin
			if (o_tmp || q_tmp > 20'd32768) begin
				f_tmp = 16'h8000;
				s_tmp = 1'b1;
			end else begin
				f_tmp = 16'(-q_tmp);
			end
		end else begin
			if (o_tmp || q_tmp > 20'd32767) begin
				f_tmp = 16'h7FFF;
				s_tmp = 1'b1;
			end else begin
				f_tmp = q_tmp[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (adv) m_axis_tvalid <= vd_q[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (mo.status)
				ST_REF_ZERO: begin
					m_axis_tdata <= '0;
					m_axis_tuser <= {1'b0, ST_REF_ZERO};
				end
				ST_CAL_EQUAL: begin
					m_axis_tdata <= {4'd0, 16'd0, f_bat, f_ref, f_p1, f_p0, f_sup};
					m_axis_tuser <= {s_volt, ST_CAL_EQUAL};
				end
				default: begin
					m_axis_tdata <= {4'd0, f_tmp, f_bat, f_ref, f_p1, f_p0, f_sup};
					m_axis_tuser <= {s_volt | s_tmp, ST_OK};
				end
			endcase
		end
	end

endmodule

// File: rtl/core/avtc_checker.sv
module avtc_checker
	import avtc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tready,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [119:0] m_axis_tdata,
	input  logic [2:0]   m_axis_tuser
);

	a_ref_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == ST_REF_ZERO |->
			m_axis_tdata == '0 && !m_axis_tuser[2])
		else $error("reference zero beat carries data");

	a_cal_equal_temp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1:0] == ST_CAL_EQUAL |-> m_axis_tdata[115:100] == '0)
		else $error("equal calibration beat carries temperature");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled beat changed");

endmodule

bind adc_vrefint_temperature_calibration avtc_checker u_avtc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);

// File: tb/adc_vrefint_temperature_calibration_test.sv
`timescale 1ns / 1ps

module adc_vrefint_temperature_calibration_test;
	import avtc_pkg::*;

	typedef struct packed {
		logic [VOLT_W-1:0] supply;
		logic [VOLT_W-1:0] pin0;
		logic [VOLT_W-1:0] pin1;
		logic [VOLT_W-1:0] vref;
		logic [VOLT_W-1:0] batt;
		logic [TEMP_W-1:0] temp;
		logic [1:0]        status;
		logic              sat;
	} calib_res_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [119:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [11:0]  cfg_wdata;

	logic [SAMPLE_W-1:0] cal_ref;
	logic [SAMPLE_W-1:0] cal_low;
	logic [SAMPLE_W-1:0] cal_high;
	calib_res_t          pending_q[$];
	int                  errors;
	bit                  quiet;
	bit                  send_gaps;
	int                  stall_left;

	adc_vrefint_temperature_calibration uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [VOLT_W-1:0] clamp_volt(longint unsigned q, inout logic sat);
		if (q > longint'(VOLT_MAX)) begin
			sat = 1'b1;
			return VOLT_MAX;
		end
		return q[VOLT_W-1:0];
	endfunction

	function automatic calib_res_t calibrate(input logic [11:0] p0, p1, rt, rr, rb);
		calib_res_t r;
		longint unsigned k, den;
		longint d, n, t;
		logic sat;
		r = '0;
		sat = 1'b0;
		if (rr == 0) begin
			r.status = ST_REF_ZERO;
			return r;
		end
		k = 64'd3300 * longint'(cal_ref) * 64'd16;
		den = longint'(rr) * 64'd4095;
		r.supply = clamp_volt(k / longint'(rr), sat);
		r.pin0 = clamp_volt(longint'(p0) * k / den, sat);
		r.pin1 = clamp_volt(longint'(p1) * k / den, sat);
		r.vref = clamp_volt(longint'(rr) * k / den, sat);
		r.batt = clamp_volt(longint'(rb) * k * 2 / den, sat);
		if (cal_high == cal_low) begin
			r.status = ST_CAL_EQUAL;
		end else begin
			d = longint'(rr) * (longint'(cal_high) - longint'(cal_low));
			n = longint'(rt) * longint'(cal_ref) - longint'(cal_low) * longint'(rr);
			t = (30 * d + 80 * n) * 16 / d;
			if (t > 32767) begin
				sat = 1'b1;
				t = 32767;
			end else if (t < -32768) begin
				sat = 1'b1;
				t = -32768;
			end
			r.temp = t[TEMP_W-1:0];
			r.status = ST_OK;
		end
		r.sat = sat;
		return r;
	endfunction

	task automatic report(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// receiver: random stall bursts
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			m_axis_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 18);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always begin
		calib_res_t got, want;
		bit hit;
		@(negedge clk);
		#1;
		hit = m_axis_tvalid && m_axis_tready && arst_n;
		got.supply = m_axis_tdata[19:0];
		got.pin0 = m_axis_tdata[39:20];
		got.pin1 = m_axis_tdata[59:40];
		got.vref = m_axis_tdata[79:60];
		got.batt = m_axis_tdata[99:80];
		got.temp = m_axis_tdata[115:100];
		got.status = m_axis_tuser[1:0];
		got.sat = m_axis_tuser[2];
		@(posedge clk);
		if (hit) begin
			if (pending_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				want = pending_q.pop_front();
				if (got.supply !== want.supply) report("supply", got.supply, want.supply);
				if (got.pin0 !== want.pin0) report("pin0", got.pin0, want.pin0);
				if (got.pin1 !== want.pin1) report("pin1", got.pin1, want.pin1);
				if (got.vref !== want.vref) report("ref", got.vref, want.vref);
				if (got.batt !== want.batt) report("batt", got.batt, want.batt);
				if (got.temp !== want.temp)
					report("temp", $signed(got.temp), $signed(want.temp));
				if (got.status !== want.status) report("status", got.status, want.status);
				if (got.sat !== want.sat) report("saturated", got.sat, want.sat);
			end
		end
	end

	task automatic send_set(input logic [11:0] p0, p1, rt, rr, rb);
		bit hit;
		@(negedge clk);
		if (send_gaps && !quiet && $urandom_range(0, 7) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, rb, rr, rt, p1, p0};
		forever begin
			#1;
			hit = s_axis_tready;
			@(posedge clk);
			if (hit)
				break;
			@(negedge clk);
		end
		pending_q.push_back(calibrate(p0, p1, rt, rr, rb));
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_REF_CAL: cal_ref = val;
			REG_TEMP_LOW: cal_low = val;
			REG_TEMP_HIGH: cal_high = val;
			default: ;
		endcase
	endtask

	task automatic set_cal(input logic [11:0] r, lo, hi);
		drain();
		write_reg(REG_REF_CAL, r);
		write_reg(REG_TEMP_LOW, lo);
		write_reg(REG_TEMP_HIGH, hi);
	endtask

	function automatic logic [11:0] pick_code();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'd4095;
			2: return 12'($urandom_range(1, 16));
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [11:0] rr;
		repeat (count) begin
			rr = pick_code();
			if ($urandom_range(0, 3) == 0)
				rr = 12'($urandom_range(1200, 1800));
			send_set(pick_code(), pick_code(), pick_code(), rr, pick_code());
		end
	endtask

	task automatic test_directed();
		send_set(12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
		send_set(12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd4095);
		send_set(12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_set(12'd0, 12'd0, 12'd0, 12'd4095, 12'd0);
		send_set(12'd4095, 12'd2048, 12'd1, 12'd1, 12'd4095);
		send_set(12'd1234, 12'd2345, 12'd1000, 12'd1500, 12'd3000);
		send_set(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
		send_set(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
		send_set(12'd1, 12'd1, 12'd4095, 12'd2, 12'd1);
		send_set(12'd100, 12'd200, 12'd0, 12'd3000, 12'd2047);
	endtask

	task automatic test_register_extremes();
		set_cal(12'd4095, 12'd0, 12'd1);
		send_set(12'd4095, 12'd0, 12'd4095, 12'd1, 12'd4095);
		send_set(12'd10, 12'd20, 12'd0, 12'd4095, 12'd30);
		set_cal(12'd1, 12'd4095, 12'd0);
		send_set(12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095);
		send_set(12'd0, 12'd0, 12'd4095, 12'd1, 12'd0);
		set_cal(12'd0, 12'd5, 12'd5);
		send_set(12'd4095, 12'd100, 12'd200, 12'd300, 12'd4095);
		set_cal(12'd4095, 12'd4095, 12'd4095);
		send_set(12'd4095, 12'd4095, 12'd4095, 12'd1, 12'd4095);
		// out-of-range index must leave the registers untouched
		drain();
		write_reg(2'd3, 12'd777);
		send_set(12'd500, 12'd600, 12'd700, 12'd800, 12'd900);
	endtask

	task automatic test_random_settings();
		set_cal(12'd1500, 12'd940, 12'd1210);
		send_random(200);
		repeat (4) begin
			set_cal(12'($urandom_range(1, 4095)), 12'($urandom_range(0, 4095)),
				12'($urandom_range(0, 4095)));
			send_random(80);
		end
	endtask

	task automatic test_pause_then_burst();
		set_cal(12'd1650, 12'd900, 12'd1300);
		send_random(60);
		drain();
		quiet = 1'b1;
		send_random(150);
	endtask

	initial begin
		errors = 0;
		quiet = 1'b0;
		send_gaps = 1'b1;
		stall_left = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_REF_CAL;
		cfg_wdata = '0;
		cal_ref = 12'd1500;
		cal_low = 12'd940;
		cal_high = 12'd1210;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(posedge clk);
		test_directed();
		test_register_extremes();
		test_random_settings();
		test_pause_then_burst();
		drain();
		if (errors == 0) begin
			$display("[adc_vrefint_temperature_calibration] OK");
		end else begin
			$display("[adc_vrefint_temperature_calibration] ERROR");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("[adc_vrefint_temperature_calibration] ERROR");
		$finish;
	end

endmodule
